// File: hw/rtl/ismu_pkg.sv
// Shared types and constants for the Ising Metropolis site update block.
// Field widths, action codes, register indexes, reset values, the command
// struct to the datapath and the status struct back. Depends on nothing.
package ismu_pkg;

  localparam int ACTION_W = 2;
  localparam int COORD_W  = 7;
  localparam int RND_W    = 16;
  localparam int DE_W     = 5;
  localparam int E_W      = 17;
  localparam int M_W      = 16;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_THRESH_FOUR  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESH_EIGHT = 1'd1;

  localparam logic [RND_W-1:0] THRESH_FOUR_RESET  = 16'd11253;
  localparam logic [RND_W-1:0] THRESH_EIGHT_RESET = 16'd1933;

  typedef enum logic [ACTION_W-1:0] {
    ACT_WRITE  = 2'd0,
    ACT_UPDATE = 2'd1,
    ACT_READ   = 2'd2
  } action_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear_step;
    logic load;
    logic read_a;
    logic read_b;
    logic commit;
  } ismu_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_done;
  } ismu_stat_t;

endpackage

// File: hw/rtl/ismu_channels.sv
// Valid/ready channel interfaces for the request and result beats.
// Depends on ismu_pkg for the field widths.
interface ismu_req_if;
  import ismu_pkg::*;

  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [COORD_W-1:0]  site_row;
  logic [COORD_W-1:0]  site_col;
  logic                write_spin;
  logic [RND_W-1:0]    random_word;

  modport source (output valid, action, site_row, site_col, write_spin, random_word,
                  input ready);
  modport sink (input valid, action, site_row, site_col, write_spin, random_word,
                output ready);
endinterface

interface ismu_rsp_if;
  import ismu_pkg::*;

  logic                   valid;
  logic                   ready;
  logic                   site_spin;
  logic                   flipped;
  logic signed [DE_W-1:0] delta_energy;
  logic signed [E_W-1:0]  total_energy;
  logic signed [M_W-1:0]  magnetization;

  modport source (output valid, site_spin, flipped, delta_energy, total_energy,
                  magnetization, input ready);
  modport sink (input valid, site_spin, flipped, delta_energy, total_energy,
                magnetization, output ready);
endinterface

// File: hw/rtl/ismu_ram.sv
// Generic RAM: one write port and two read ports with registered read data.
// Self-contained, no package needed.
module ismu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic                     re_b,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re_a) begin
      rdata_a <= mem[raddr_a];
    end
    if (re_b) begin
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

// File: hw/rtl/ismu_ctrl.sv
// Controller state machine: clearing pass, request accept, the two read
// phases, and the commit into the result register. Depends on ismu_pkg.
module ismu_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  output ismu_pkg::ismu_cmd_t   cmd,
  input  ismu_pkg::ismu_stat_t  stat
);
  import ismu_pkg::*;

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_RD1   = 5'b00100,
    ST_RD2   = 5'b01000,
    ST_EVAL  = 5'b10000
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (stat.clear_done) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_RD1;
        end
      end
      ST_RD1: begin
        cmd.read_a = 1'b1;
        state_next = ST_RD2;
      end
      ST_RD2: begin
        cmd.read_b = 1'b1;
        state_next = ST_EVAL;
      end
      ST_EVAL: begin
        // Commit only when the result register is free or being emptied.
        if (!out_valid || out_ready) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// File: hw/rtl/ismu_datapath.sv
// Datapath: row-wide spin memory, coordinate reduction, neighbor gather,
// acceptance test, running totals and the result register.
// Depends on ismu_pkg and ismu_ram.
module ismu_datapath #(
  parameter int SIDE = 128
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  ismu_pkg::ismu_cmd_t                     cmd,
  output ismu_pkg::ismu_stat_t                    stat,
  input  logic                                    cfg_write_en,
  input  logic [ismu_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [ismu_pkg::CFG_DATA_W-1:0]         cfg_data,
  input  logic [ismu_pkg::ACTION_W-1:0]           action,
  input  logic [ismu_pkg::COORD_W-1:0]            site_row,
  input  logic [ismu_pkg::COORD_W-1:0]            site_col,
  input  logic                                    write_spin,
  input  logic [ismu_pkg::RND_W-1:0]              random_word,
  output logic                                    site_spin,
  output logic                                    flipped,
  output logic signed [ismu_pkg::DE_W-1:0]        delta_energy,
  output logic signed [ismu_pkg::E_W-1:0]         total_energy,
  output logic signed [ismu_pkg::M_W-1:0]         magnetization
);
  import ismu_pkg::*;

  localparam int RW = $clog2(SIDE);
  localparam logic [RW-1:0]  LAST     = RW'(SIDE - 1);
  localparam logic [E_W-1:0] E_RESET  = E_W'(-2 * SIDE * SIDE);
  localparam logic [M_W-1:0] M_RESET  = M_W'(SIDE * SIDE);

  // Coordinate modulo SIDE by restoring subtraction of shifted SIDE.
  function automatic logic [RW-1:0] reduce_coord(input logic [COORD_W-1:0] v);
    logic [COORD_W-1:0] x;
    x = v;
    for (int k = COORD_W - 1; k >= 0; k--) begin
      if (SIDE * (2 ** k) <= int'(x)) begin
        x = x - COORD_W'(SIDE * (2 ** k));
      end
    end
    return RW'(x);
  endfunction

  logic [RW-1:0]    row, col;
  action_t          act;
  logic             wspin;
  logic [RND_W-1:0] rnd;
  logic [RND_W-1:0] th_four, th_eight;
  logic [RW-1:0]    clr_cnt;
  logic [SIDE-1:0]  up_word;
  logic signed [E_W-1:0] energy, energy_next;
  logic signed [M_W-1:0] magnet, magnet_next;

  logic [RW-1:0]   up_row, down_row, left_col, right_col;
  logic            ram_we, ram_re_a;
  logic [RW-1:0]   ram_waddr, ram_raddr_a;
  logic [SIDE-1:0] ram_wdata, rd_a, rd_b, col_mask;

  logic            s, n_up, n_dn, n_l, n_r, flip;
  logic [2:0]      same;
  logic signed [DE_W-1:0] dh;

  // Item capture and configuration registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      row   <= reduce_coord(site_row);
      col   <= reduce_coord(site_col);
      act   <= action_t'(action);
      wspin <= write_spin;
      rnd   <= random_word;
    end
    if (cmd.read_b) begin
      up_word <= rd_a;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      th_four  <= THRESH_FOUR_RESET;
      th_eight <= THRESH_EIGHT_RESET;
    end else if (cfg_write_en) begin
      if (cfg_index == CFG_THRESH_FOUR) begin
        th_four <= cfg_data;
      end else if (cfg_index == CFG_THRESH_EIGHT) begin
        th_eight <= cfg_data;
      end
    end
  end

  // Torus neighbors.
  assign up_row    = (row == '0)   ? LAST : row - 1'b1;
  assign down_row  = (row == LAST) ? '0   : row + 1'b1;
  assign left_col  = (col == '0)   ? LAST : col - 1'b1;
  assign right_col = (col == LAST) ? '0   : col + 1'b1;

  // First read phase fetches the upper and center rows, the second the lower row.
  assign ram_re_a    = cmd.read_a | cmd.read_b;
  assign ram_raddr_a = cmd.read_b ? down_row : up_row;

  ismu_ram #(
    .WIDTH (SIDE),
    .DEPTH (SIDE)
  ) u_spin_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .re_a    (ram_re_a),
    .raddr_a (ram_raddr_a),
    .rdata_a (rd_a),
    .re_b    (cmd.read_a),
    .raddr_b (row),
    .rdata_b (rd_b)
  );

  // Evaluation: rd_b holds the center row, rd_a the lower row.
  always_comb begin
    s    = rd_b[col];
    n_l  = rd_b[left_col];
    n_r  = rd_b[right_col];
    n_up = up_word[col];
    n_dn = rd_a[col];
    // Number of neighbors aligned with the site; dH is 4*same - 8.
    same = {2'b00, n_up ~^ s} + {2'b00, n_dn ~^ s} + {2'b00, n_l ~^ s}
         + {2'b00, n_r ~^ s};
    dh   = DE_W'({same, 2'b00}) - DE_W'(8);
    unique case (act)
      ACT_WRITE: begin
        flip = (wspin != s);
      end
      ACT_UPDATE: begin
        if (same <= 3'd2) begin
          flip = 1'b1;
        end else if (same == 3'd3) begin
          flip = (rnd <= th_four);
        end else begin
          flip = (rnd <= th_eight);
        end
      end
      default: begin
        flip = 1'b0;
      end
    endcase
    energy_next = energy + {{(E_W - DE_W){dh[DE_W-1]}}, dh};
    magnet_next = s ? magnet - M_W'(2) : magnet + M_W'(2);
  end

  assign col_mask  = {{(SIDE - 1){1'b0}}, 1'b1} << col;
  assign ram_we    = cmd.clear_step | (cmd.commit & flip);
  assign ram_waddr = cmd.clear_step ? clr_cnt : row;
  assign ram_wdata = cmd.clear_step ? {SIDE{1'b1}} : (rd_b ^ col_mask);

  assign stat.clear_done = (clr_cnt == LAST);

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
      energy  <= E_RESET;
      magnet  <= M_RESET;
    end else begin
      if (cmd.clear_step && !stat.clear_done) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (cmd.commit && flip) begin
        energy <= energy_next;
        magnet <= magnet_next;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      site_spin     <= s ^ flip;
      flipped       <= flip;
      delta_energy  <= flip ? dh : '0;
      total_energy  <= flip ? energy_next : energy;
      magnetization <= flip ? magnet_next : magnet;
    end
  end

endmodule

// File: hw/rtl/ising_metropolis_site_update_top.sv
// Top level of the Ising Metropolis site update block.
// Depends on ismu_pkg, the channel interfaces, ismu_ctrl and ismu_datapath.
//
// This block holds a SIDE x SIDE torus of +1/-1 spins, one lattice row per
// memory word, and applies one request beat at a time: write a spin, read a
// spin, or run a Metropolis update with the supplied random word against the
// two programmable thresholds. Every request yields exactly one result beat
// carrying the site's spin afterwards, whether it flipped, the energy change,
// and the running energy and magnetization totals (reported modulo their
// field widths). Row and column are reduced modulo SIDE; action code 3 acts
// as a read. After reset the block runs a clearing pass that writes every
// row and sets every spin to +1; requests are held off during that pass,
// while threshold writes are taken at any time. Each request then goes
// from accept to result through capture of the item, two read phases on
// the dual-read spin memory (upper and center rows, then the lower row),
// and evaluation, which writes back the row if the spin flipped and loads the
// result register. The next request is taken as soon as the previous one has
// committed, even if its result beat is still waiting on the consumer; a
// commit waits only while the result register is still full. Threshold
// registers must be written only while no request is in flight.
module ising_metropolis_site_update_top #(
  parameter int SIDE = 128
) (
  input  logic                             clk,
  input  logic                             rst,
  ismu_req_if.sink                         req,
  ismu_rsp_if.source                       rsp,
  input  logic                             cfg_write_en,
  input  logic [ismu_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ismu_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import ismu_pkg::*;

  ismu_cmd_t  cmd;
  ismu_stat_t stat;

  // The controller sequences the phases and owns both handshakes.
  ismu_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  // The datapath holds the lattice, the totals and the result payload.
  ismu_datapath #(
    .SIDE (SIDE)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .cfg_write_en  (cfg_write_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .action        (req.action),
    .site_row      (req.site_row),
    .site_col      (req.site_col),
    .write_spin    (req.write_spin),
    .random_word   (req.random_word),
    .site_spin     (rsp.site_spin),
    .flipped       (rsp.flipped),
    .delta_energy  (rsp.delta_energy),
    .total_energy  (rsp.total_energy),
    .magnetization (rsp.magnetization)
  );

  // Only one request is in flight: an accept is never followed at once by another.
  assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("request accepted while previous one still in flight");

  // No request is taken in the first cycle after reset, during the clearing pass.
  assert property (@(posedge clk) $fell(rst) |-> !req.ready)
    else $error("request ready during clearing pass");

  // A result that did not flip reports no energy change.
  assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.flipped) |-> (rsp.delta_energy == '0))
    else $error("energy change reported without a flip");

  // Every reported energy change is a multiple of four.
  assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (rsp.delta_energy[1:0] == 2'b00))
    else $error("energy change not a multiple of four");

endmodule
